@@ hw/rtl/mbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  // working number format
  localparam int WORK_BITS     = 40;
  localparam int MAG_W         = WORK_BITS - 1;
  localparam int PROD_W        = 2 * MAG_W;
  localparam int MUL_LO_W      = 20;
  localparam int MUL_HI_W      = MAG_W - MUL_LO_W;
  localparam int DEF_FRAC_BITS = 28;
  localparam int DEF_MAX_DIM   = 4096;

  // field widths
  localparam int WIN_W     = 32;
  localparam int SIZE_W    = 13;
  localparam int ITER_W    = 16;
  localparam int IDX_W     = 12;
  localparam int CFG_IDX_W = 3;

  // coordinate divider: |(max-min)*index| stays below 2^44
  localparam int DIVD_W = 45;
  localparam int DIVS_W = SIZE_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd6;

  // register reset values
  localparam logic [WIN_W-1:0]  RST_REAL_MIN = 32'hE000_0000;
  localparam logic [WIN_W-1:0]  RST_REAL_MAX = 32'h1000_0000;
  localparam logic [WIN_W-1:0]  RST_IMAG_MIN = 32'hF000_0000;
  localparam logic [WIN_W-1:0]  RST_IMAG_MAX = 32'h1000_0000;
  localparam logic [SIZE_W-1:0] RST_WIDTH    = 13'd640;
  localparam logic [SIZE_W-1:0] RST_HEIGHT   = 13'd480;
  localparam logic [ITER_W-1:0] RST_MAX_ITER = 16'd256;

  // product selection
  typedef logic [1:0] op_t;
  localparam op_t OP_XX = 2'd0;
  localparam op_t OP_YY = 2'd1;
  localparam op_t OP_XY = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
  } in_data_t;

  typedef struct packed {
    logic [ITER_W-1:0] escape_count;
    logic              inside_res;
  } out_data_t;

  typedef struct packed {
    logic load;
    logic map_y;
    logic map_mul;
    logic div_start;
    logic map_add;
    op_t  op;
    logic mul_lo;
    logic mul_hi;
    logic mul_st;
    logic upd;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cont;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/mbe_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module mbe_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [mbe_pkg::DIVD_W-1:0]  dividend,
  input  wire [mbe_pkg::DIVS_W-1:0]  divisor,
  output logic [mbe_pkg::DIVD_W-1:0] quotient,
  output logic                       done
);

  localparam int W     = mbe_pkg::DIVD_W;
  localparam int D     = mbe_pkg::DIVS_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r, quo_nxt;
  logic [D-1:0]     rem_r, rem_nxt;
  logic [D-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [D:0]       rem_sh;
  logic [D:0]       rem_sub;
  logic             fits;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    fits     = (rem_sh >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[W-2:0], fits};
      rem_nxt  = fits ? rem_sub[D-1:0] : rem_sh[D-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

@@ hw/rtl/mbe_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbe_datapath #(
  parameter int MAX_DIM   = mbe_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = mbe_pkg::DEF_FRAC_BITS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [mbe_pkg::WIN_W-1:0]      cfg_data,
  input  wire mbe_pkg::in_data_t        in_data,
  input  wire mbe_pkg::cmd_t            cmd,
  output mbe_pkg::sts_t                 sts,
  output mbe_pkg::out_data_t            out_data
);

  localparam int WB      = mbe_pkg::WORK_BITS;
  localparam int MW      = mbe_pkg::MAG_W;
  localparam int PW      = mbe_pkg::PROD_W;
  localparam int LW      = mbe_pkg::MUL_LO_W;
  localparam int SW      = mbe_pkg::SIZE_W;
  localparam int DVW     = mbe_pkg::DIVD_W;
  localparam int SATIN_W = 48;
  localparam int DIM_LIM = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam logic [SW-1:0]        DIM_LIM_V = SW'(DIM_LIM);
  localparam logic [MW-1:0]        SAT_MAG   = {MW{1'b1}};
  localparam logic [SATIN_W-1:0]   SAT_HI    = SATIN_W'({MW{1'b1}});
  localparam logic [63:0]          FOUR      = 64'd4 << FRAC_BITS;

  function automatic logic [WB-1:0] sat_work(input logic [SATIN_W-1:0] v);
    logic signed [SATIN_W-1:0] sv;
    logic [WB-1:0]             res;
    sv = $signed(v);
    if (sv > $signed(SAT_HI)) res = WB'(SAT_HI);
    else if (sv < -$signed(SAT_HI)) res = WB'(-SAT_HI);
    else res = v[WB-1:0];
    return res;
  endfunction

  // configuration registers
  logic [mbe_pkg::WIN_W-1:0]  real_min_r, real_max_r, imag_min_r, imag_max_r;
  logic [SW-1:0]              width_r, height_r;
  logic [mbe_pkg::ITER_W-1:0] iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_min_r <= mbe_pkg::RST_REAL_MIN;
      real_max_r <= mbe_pkg::RST_REAL_MAX;
      imag_min_r <= mbe_pkg::RST_IMAG_MIN;
      imag_max_r <= mbe_pkg::RST_IMAG_MAX;
      width_r    <= mbe_pkg::RST_WIDTH;
      height_r   <= mbe_pkg::RST_HEIGHT;
      iter_r     <= mbe_pkg::RST_MAX_ITER;
    end else if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::CFG_REAL_MIN: real_min_r <= cfg_data;
        mbe_pkg::CFG_REAL_MAX: real_max_r <= cfg_data;
        mbe_pkg::CFG_IMAG_MIN: imag_min_r <= cfg_data;
        mbe_pkg::CFG_IMAG_MAX: imag_max_r <= cfg_data;
        mbe_pkg::CFG_WIDTH:    width_r    <= cfg_data[SW-1:0];
        mbe_pkg::CFG_HEIGHT:   height_r   <= cfg_data[SW-1:0];
        mbe_pkg::CFG_MAX_ITER: iter_r     <= cfg_data[mbe_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate mapping
  logic [mbe_pkg::IDX_W-1:0] col_r, row_r;
  logic [mbe_pkg::WIN_W-1:0] sel_lo, sel_hi;
  logic [mbe_pkg::IDX_W-1:0] sel_idx;
  logic [SW-1:0]             sel_size, eff_size, dvs;
  logic signed [32:0]        diff;
  logic signed [45:0]        map_prod, map_prod_r;
  logic [45:0]               prod_mag;
  logic                      prod_neg;
  logic [DVW-1:0]            quo;
  logic [45:0]               quo_s;
  logic [SATIN_W-1:0]        map_sum;
  logic [WB-1:0]             cx_r, cy_r;
  logic                      div_done;

  always_comb begin
    sel_lo   = cmd.map_y ? imag_min_r : real_min_r;
    sel_hi   = cmd.map_y ? imag_max_r : real_max_r;
    sel_idx  = cmd.map_y ? row_r : col_r;
    sel_size = cmd.map_y ? height_r : width_r;
    eff_size = (32'(sel_size) > 32'(MAX_DIM)) ? DIM_LIM_V : sel_size;
    dvs      = (eff_size < SW'(2)) ? SW'(1) : eff_size - SW'(1);
    diff     = $signed({sel_hi[31], sel_hi}) - $signed({sel_lo[31], sel_lo});
    map_prod = diff * $signed({1'b0, sel_idx});
    prod_neg = map_prod_r[45];
    prod_mag = prod_neg ? 46'(-map_prod_r) : 46'(map_prod_r);
    quo_s    = prod_neg ? -{1'b0, quo} : {1'b0, quo};
    map_sum  = {{(SATIN_W-32){sel_lo[31]}}, sel_lo}
             + {{(SATIN_W-46){quo_s[45]}}, quo_s};
  end

  mbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_mag[DVW-1:0]),
    .divisor  (dvs),
    .quotient (quo),
    .done     (div_done)
  );

  // escape iteration
  logic [WB-1:0]            x_r, y_r, xy_r;
  logic [MW-1:0]            xx_r, yy_r;
  logic [mbe_pkg::ITER_W-1:0] n_r;
  logic [WB-1:0]            op_a, op_b, neg_a, neg_b;
  logic [MW-1:0]            mag_a, mag_b;
  logic [LW-1:0]            mb_half;
  logic [PW-1:0]            mprod_r, pp, sh;
  logic [MW-1:0]            msat;
  logic                     xy_neg;
  logic [SATIN_W-1:0]       ux_sum, uy_sum;
  logic                     esc_ok;

  always_comb begin
    op_a    = (cmd.op == mbe_pkg::OP_YY) ? y_r : x_r;
    op_b    = (cmd.op == mbe_pkg::OP_XX) ? x_r : y_r;
    neg_a   = -op_a;
    neg_b   = -op_b;
    mag_a   = op_a[WB-1] ? neg_a[MW-1:0] : op_a[MW-1:0];
    mag_b   = op_b[WB-1] ? neg_b[MW-1:0] : op_b[MW-1:0];
    // one multiplier, low half of b first, high half on the next cycle
    mb_half = cmd.mul_hi ? LW'(mag_b[MW-1:LW]) : mag_b[LW-1:0];
    pp      = PW'(mag_a * mb_half);
    sh      = mprod_r >> FRAC_BITS;
    msat    = (|sh[PW-1:MW]) ? SAT_MAG : sh[MW-1:0];
    xy_neg  = x_r[WB-1] ^ y_r[WB-1];
    ux_sum  = {{(SATIN_W-MW){1'b0}}, xx_r} - {{(SATIN_W-MW){1'b0}}, yy_r}
            + {{(SATIN_W-WB){cx_r[WB-1]}}, cx_r};
    uy_sum  = {{(SATIN_W-WB-1){xy_r[WB-1]}}, xy_r, 1'b0}
            + {{(SATIN_W-WB){cy_r[WB-1]}}, cy_r};
    esc_ok  = ((64'(xx_r) + 64'(yy_r)) <= FOUR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (cmd.load) begin
      n_r <= '0;
    end else if (cmd.upd) begin
      n_r <= n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_data.column;
      row_r <= in_data.row;
      x_r   <= '0;
      y_r   <= '0;
    end
    if (cmd.map_mul) map_prod_r <= map_prod;
    if (cmd.map_add) begin
      if (cmd.map_y) cy_r <= sat_work(map_sum);
      else cx_r <= sat_work(map_sum);
    end
    if (cmd.mul_lo) mprod_r <= pp;
    if (cmd.mul_hi) mprod_r <= mprod_r + (pp << LW);
    if (cmd.mul_st) begin
      case (cmd.op)
        mbe_pkg::OP_XX: xx_r <= msat;
        mbe_pkg::OP_YY: yy_r <= msat;
        default:        xy_r <= xy_neg ? -{1'b0, msat} : {1'b0, msat};
      endcase
    end
    if (cmd.upd) begin
      x_r <= sat_work(ux_sum);
      y_r <= sat_work(uy_sum);
    end
    if (cmd.res_load) begin
      out_data.escape_count <= n_r;
      out_data.inside_res   <= (n_r == iter_r);
    end
  end

  assign sts.div_done = div_done;
  assign sts.cont     = (n_r < iter_r) && esc_ok;

endmodule

`default_nettype wire

@@ hw/rtl/mbe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbe_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire mbe_pkg::sts_t  sts,
  output mbe_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                out_valid
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MAP_MUL  = 4'd1;
  localparam logic [3:0] ST_MAP_DIV  = 4'd2;
  localparam logic [3:0] ST_MAP_WAIT = 4'd3;
  localparam logic [3:0] ST_MAP_ADD  = 4'd4;
  localparam logic [3:0] ST_MUL_LO   = 4'd5;
  localparam logic [3:0] ST_MUL_HI   = 4'd6;
  localparam logic [3:0] ST_MUL_ST   = 4'd7;
  localparam logic [3:0] ST_UPD      = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic              axis_r, axis_nxt;
  mbe_pkg::op_t      op_r, op_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    op_nxt        = op_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.map_y     = axis_r;
    cmd.op        = op_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          axis_nxt  = 1'b0;
          state_nxt = ST_MAP_MUL;
        end
      end
      ST_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_nxt   = ST_MAP_DIV;
      end
      ST_MAP_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_MAP_WAIT;
      end
      ST_MAP_WAIT: begin
        if (sts.div_done) state_nxt = ST_MAP_ADD;
      end
      ST_MAP_ADD: begin
        cmd.map_add = 1'b1;
        if (axis_r) begin
          op_nxt    = mbe_pkg::OP_XX;
          state_nxt = ST_MUL_LO;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = ST_MAP_MUL;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_MUL_ST;
      end
      ST_MUL_ST: begin
        cmd.mul_st = 1'b1;
        if (op_r == mbe_pkg::OP_XY) begin
          state_nxt = ST_UPD;
        end else begin
          op_nxt    = op_r + 1'b1;
          state_nxt = ST_MUL_LO;
        end
      end
      ST_UPD: begin
        if (sts.cont) begin
          cmd.upd   = 1'b1;
          op_nxt    = mbe_pkg::OP_XX;
          state_nxt = ST_MUL_LO;
        end else begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 1'b0;
      op_r        <= mbe_pkg::OP_XX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hw/rtl/mandelbrot_escape_time_pixel.sv @@
`timescale 1ns / 1ps
// sequence: coordinate mapping (two 45-step serial divisions), then escape_count + 1
//   passes of z = z*z + c, result strobe in the cycle after the final pass
// one pixel at a time, the z products share one 39x20 multiplier; start is taken again
//   when busy drops
// results strobe on out_valid for one cycle and cannot be stalled by the receiver
// reset: synchronous active-low rst_n idles the controller, window -2..1 by -1..1, 640x480, 256
`default_nettype none

module mandelbrot_escape_time_pixel #(
  parameter int MAX_DIM   = mbe_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = mbe_pkg::DEF_FRAC_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // pixel command: transfer when start is high and busy is low
  input  wire                          start,
  output logic                         busy,
  input  wire mbe_pkg::in_data_t       in_data,
  // result strobe, one cycle per pixel
  output logic                         out_valid,
  output mbe_pkg::out_data_t           out_data,
  // register write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [mbe_pkg::WIN_W-1:0]     cfg_data
);

  mbe_pkg::cmd_t cmd;
  mbe_pkg::sts_t sts;
  logic          cfg_we;

  // writes must only arrive while idle, which the block does not enforce; the register file always takes them
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // sequencer: mapping, divider handshake, product order and the escape decision
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // registers, coordinate mapping with serial divider, multiplier and z update
  mbe_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // index with no register behind it, writes there must be dropped
  localparam logic [mbe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  // working range of the 40-bit datapath, symmetric around zero
  localparam longint SAT_MAX = (longint'(1) << (mbe_pkg::WORK_BITS - 1)) - 1;
  // escape radius squared in the working format
  localparam longint FOUR    = longint'(4) << mbe_pkg::DEF_FRAC_BITS;

  // one pixel in flight together with the result it must produce
  typedef struct {
    mbe_pkg::in_data_t  px;
    mbe_pkg::out_data_t want;
  } escape_check_t;

  // ---------------------------------------------------------------------------
  // clock and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          start     = 1'b0;
  mbe_pkg::in_data_t             in_data   = '0;
  logic                          cfg_valid = 1'b0;
  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mbe_pkg::WIN_W-1:0]     cfg_data  = '0;

  logic               busy;
  logic               out_valid;
  mbe_pkg::out_data_t out_data;
  logic               cfg_ready;

  always #5 clk = ~clk;

  mandelbrot_escape_time_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the register file, tracks every accepted config transfer
  // ---------------------------------------------------------------------------
  longint      re_lo      = longint'(signed'(mbe_pkg::RST_REAL_MIN));
  longint      re_hi      = longint'(signed'(mbe_pkg::RST_REAL_MAX));
  longint      im_lo      = longint'(signed'(mbe_pkg::RST_IMAG_MIN));
  longint      im_hi      = longint'(signed'(mbe_pkg::RST_IMAG_MAX));
  int unsigned cols       = mbe_pkg::RST_WIDTH;
  int unsigned rows       = mbe_pkg::RST_HEIGHT;
  int unsigned iter_limit = mbe_pkg::RST_MAX_ITER;

  // ---------------------------------------------------------------------------
  // bookkeeping shared by the sequencer, driver and monitor
  // ---------------------------------------------------------------------------
  mbe_pkg::in_data_t pixel_queue[$];   // pixels waiting to be driven
  escape_check_t     escape_queue[$];  // accepted pixels waiting for their result
  int            n_issued   = 0;   // pixels put on the bus
  int            n_accepted = 0;   // pixels taken by the block
  int            hold_off   = 0;   // idle cycles before the next pixel
  bit            steady     = 1'b0; // phase without any idling on the pixel port
  int            errors     = 0;
  int            n_inside   = 0;
  int            deepest    = 0;
  int            settings_run = 0;

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------

  // clamp to the symmetric working range
  function automatic longint clamp_work(input longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < -SAT_MAX) return -SAT_MAX;
    return v;
  endfunction

  // sign-magnitude product, truncated toward zero, magnitude saturated
  function automatic longint fix_mul(input longint a, input longint b);
    logic [79:0] prod;
    longint      mag;
    logic        neg;
    neg  = (a < 0) != (b < 0);
    prod = 80'(a < 0 ? -a : a) * 80'(b < 0 ? -b : b);
    prod = prod >> mbe_pkg::DEF_FRAC_BITS;
    mag  = (prod > 80'(SAT_MAX)) ? SAT_MAX : longint'(prod[63:0]);
    return neg ? -mag : mag;
  endfunction

  // linear map of a pixel index onto one axis of the window
  function automatic longint map_axis(input longint lo, input longint hi,
                                      input longint index, input int unsigned size);
    longint divisor;
    // oversized images behave as the largest supported one
    if (size > mbe_pkg::DEF_MAX_DIM) size = mbe_pkg::DEF_MAX_DIM;
    // degenerate sizes divide by one
    divisor = (size < 2) ? 1 : longint'(size) - 1;
    // signed division truncates toward zero
    return clamp_work(lo + ((hi - lo) * index) / divisor);
  endfunction

  // escape count and inside flag for one pixel under the current settings
  function automatic mbe_pkg::out_data_t escape_time(input mbe_pkg::in_data_t px);
    longint             cx, cy, x, y, xx, yy, xy;
    int unsigned        n;
    mbe_pkg::out_data_t r;
    cx = map_axis(re_lo, re_hi, longint'(px.column), cols);
    cy = map_axis(im_lo, im_hi, longint'(px.row), rows);
    x  = 0;
    y  = 0;
    xx = 0;
    yy = 0;
    n  = 0;
    // squares are never negative, so the unsaturated sum compares directly
    while (n < iter_limit && xx + yy <= FOUR) begin
      xy = fix_mul(x, y);
      x  = clamp_work(xx - yy + cx);
      y  = clamp_work(xy + xy + cy);
      n++;
      xx = fix_mul(x, x);
      yy = fix_mul(y, y);
    end
    r.escape_count = n[mbe_pkg::ITER_W-1:0];
    r.inside_res   = (n == iter_limit);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  // mostly back to back or short pauses, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 40);
    return $urandom_range(41, 400);
  endfunction

  // image dimension, including the degenerate and oversized encodings
  function automatic int unsigned pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(2, 64);
    if (r < 75) return $urandom_range(65, 4096);
    if (r < 85) return 4096;
    if (r < 90) return 2;
    if (r < 95) return $urandom_range(0, 1);
    return $urandom_range(4097, 8191);
  endfunction

  // garbage above the field width must not leak into the register
  function automatic logic [31:0] with_junk(input logic [31:0] v, input int keep);
    logic [31:0] mask;
    mask = 32'hFFFF_FFFF << keep;
    return ($urandom_range(0, 2) == 0) ? (v | ($urandom() & mask)) : v;
  endfunction

  // mostly inside the image, sometimes anywhere in the 12-bit range
  function automatic logic [mbe_pkg::IDX_W-1:0] pick_index(input int unsigned size);
    int unsigned top;
    top = (size > mbe_pkg::DEF_MAX_DIM) ? mbe_pkg::DEF_MAX_DIM : size;
    if (top < 2 || $urandom_range(0, 4) == 0) begin
      return mbe_pkg::IDX_W'($urandom_range(0, 4095));
    end
    return mbe_pkg::IDX_W'($urandom_range(0, top - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: inputs move on the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || n_accepted == n_issued) begin
      // bus is free: the last pixel, if any, has been transferred
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        start    <= 1'b0;
        in_data  <= mbe_pkg::in_data_t'($urandom());
      end else if (pixel_queue.size() != 0) begin
        in_data  <= pixel_queue.pop_front();
        start    <= 1'b1;
        n_issued <= n_issued + 1;
        hold_off <= steady ? 0 : pick_gap();
      end else begin
        start   <= 1'b0;
        in_data <= mbe_pkg::in_data_t'($urandom());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples on the rising edge, checks results before logging new pixels
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    escape_check_t ref_item;
    if (rst_n) begin
      if (out_valid) begin
        if (escape_queue.size() == 0) begin
          note_mismatch($sformatf("result count %0d inside %0b with no pixel outstanding",
                                  out_data.escape_count, out_data.inside_res));
        end else begin
          ref_item = escape_queue.pop_front();
          if (out_data.escape_count !== ref_item.want.escape_count ||
              out_data.inside_res !== ref_item.want.inside_res) begin
            note_mismatch($sformatf(
              "pixel (%0d,%0d): expected count %0d inside %0b, got count %0d inside %0b",
              ref_item.px.column, ref_item.px.row, ref_item.want.escape_count,
              ref_item.want.inside_res, out_data.escape_count, out_data.inside_res));
          end
        end
        if (out_data.inside_res === 1'b1) n_inside++;
        if (out_data.escape_count > deepest) deepest = out_data.escape_count;
      end
      // pixel transfer at this edge
      if (start && !busy) begin
        ref_item.px   = in_data;
        ref_item.want = escape_time(in_data);
        escape_queue.push_back(ref_item);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer tasks
  // ---------------------------------------------------------------------------

  // one config transfer, shadow registers follow on acceptance
  task automatic write_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mbe_pkg::CFG_REAL_MIN: re_lo      = longint'(signed'(data));
      mbe_pkg::CFG_REAL_MAX: re_hi      = longint'(signed'(data));
      mbe_pkg::CFG_IMAG_MIN: im_lo      = longint'(signed'(data));
      mbe_pkg::CFG_IMAG_MAX: im_hi      = longint'(signed'(data));
      mbe_pkg::CFG_WIDTH:    cols       = data[mbe_pkg::SIZE_W-1:0];
      mbe_pkg::CFG_HEIGHT:   rows       = data[mbe_pkg::SIZE_W-1:0];
      mbe_pkg::CFG_MAX_ITER: iter_limit = data[mbe_pkg::ITER_W-1:0];
      default: ;  // spare index, nothing changes
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(0, 3)) @(negedge clk);
  endtask

  // full register set for a new view
  task automatic load_view(input logic [31:0] rlo, input logic [31:0] rhi,
                           input logic [31:0] ilo, input logic [31:0] ihi,
                           input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] iters);
    write_reg(mbe_pkg::CFG_REAL_MIN, rlo);
    write_reg(mbe_pkg::CFG_REAL_MAX, rhi);
    write_reg(mbe_pkg::CFG_IMAG_MIN, ilo);
    write_reg(mbe_pkg::CFG_IMAG_MAX, ihi);
    write_reg(mbe_pkg::CFG_WIDTH, w);
    write_reg(mbe_pkg::CFG_HEIGHT, h);
    write_reg(mbe_pkg::CFG_MAX_ITER, iters);
    settings_run++;
  endtask

  task automatic add_pixel(input int unsigned c, input int unsigned r);
    mbe_pkg::in_data_t px;
    px.column = c[mbe_pkg::IDX_W-1:0];
    px.row    = r[mbe_pkg::IDX_W-1:0];
    pixel_queue.push_back(px);
  endtask

  // block idle: nothing queued, nothing on the bus, every result back
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || start || busy || escape_queue.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    longint      re_c, re_h, im_c, im_h, esc;
    logic [31:0] wr_lo, wr_hi, wi_lo, wi_hi, swap;
    int unsigned iters, n_items;
    int          kind, ikind, random_items;

    random_items = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset view: corners, a point inside the set, indexes past the image
    add_pixel(0, 0);
    add_pixel(639, 479);
    add_pixel(426, 240);
    add_pixel(4095, 4095);
    wait_drained();

    // zero iteration limit, zero width, one row, extreme window words
    load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'hFFFF_E000, 32'h0000_0001, 32'hFFFF_0000);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    wait_drained();

    // single iteration, the far column saturates the real part
    write_reg(mbe_pkg::CFG_MAX_ITER, 32'h0001_0001);
    add_pixel(0, 0);
    add_pixel(4095, 0);
    wait_drained();

    // largest limit, but the imaginary part keeps every point outside
    write_reg(mbe_pkg::CFG_MAX_ITER, 32'h0000_FFFF);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(1, 2);
    wait_drained();

    // reversed window, oversized width, full height, smallest sane limit
    load_view(32'h1000_0000, 32'hE000_0000, 32'h1400_0000, 32'hEC00_0000,
              32'hA5A5_FFFF, 32'h0000_1000, 32'h0000_0002);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(2730, 2048);
    add_pixel(4095, 4095);
    wait_drained();

    // two by two image, extrapolation far past the last column
    load_view(32'hE000_0000, 32'h1000_0000, 32'hF000_0000, 32'h1000_0000,
              32'd2, 32'd2, 32'd16);
    add_pixel(0, 0);
    add_pixel(1, 1);
    add_pixel(0, 1);
    add_pixel(4095, 3);
    wait_drained();

    // random views, each one programmed while the block is idle
    while (random_items < 1800) begin
      kind = $urandom_range(0, 99);
      // window centered around the interesting part of the plane
      re_c  = longint'($urandom_range(0, 805306368)) - 603979776;
      re_h  = longint'($urandom_range(1024, 402653184));
      im_c  = longint'($urandom_range(0, 536870912)) - 268435456;
      im_h  = longint'($urandom_range(1024, 335544320));
      wr_lo = 32'(re_c - re_h);
      wr_hi = 32'(re_c + re_h);
      wi_lo = 32'(im_c - im_h);
      wi_hi = 32'(im_c + im_h);
      if (kind < 25) begin
        // arbitrary words, reaches every bit of the window registers
        wr_lo = $urandom();
        wr_hi = $urandom();
        wi_lo = $urandom();
        wi_hi = $urandom();
      end else if (kind < 40) begin
        // descending mapping on both axes
        swap  = wr_lo;
        wr_lo = wr_hi;
        wr_hi = swap;
        swap  = wi_lo;
        wi_lo = wi_hi;
        wi_hi = swap;
      end else if (kind < 48) begin
        // zero span, every pixel lands on the same point
        wr_hi = wr_lo;
        wi_hi = wi_lo;
      end

      ikind   = $urandom_range(0, 99);
      n_items = $urandom_range(60, 180);
      if (ikind < 60) begin
        iters = $urandom_range(0, 24);
      end else if (ikind < 85) begin
        iters   = $urandom_range(25, 64);
        n_items = $urandom_range(30, 90);
      end else if (ikind < 95) begin
        // long limit kept cheap: |c_im| above 2 escapes on the first pass
        iters = $urandom_range(65, 65535);
        esc   = longint'($urandom_range(603979776, 2147483647));
        if ($urandom_range(0, 1) == 1) esc = -esc;
        wi_lo = 32'(esc);
        wi_hi = wi_lo;
      end else begin
        // deep iterations on a handful of pixels
        iters   = $urandom_range(65, 400);
        n_items = $urandom_range(8, 16);
      end

      load_view(wr_lo, wr_hi, wi_lo, wi_hi,
                with_junk(pick_size(), mbe_pkg::SIZE_W),
                with_junk(pick_size(), mbe_pkg::SIZE_W),
                with_junk(iters, mbe_pkg::ITER_W));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom());

      steady = ($urandom_range(0, 3) == 0);
      repeat (n_items) add_pixel(pick_index(cols), pick_index(rows));
      random_items += n_items;
      wait_drained();
    end

    // quiet tail catches any stray result
    repeat (600) @(posedge clk);
    $display("checked %0d pixels across %0d register settings", n_accepted, settings_run);
    $display("%0d pixels reported inside, deepest escape count %0d, %0d bad results",
             n_inside, deepest, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(400_000_000);
    $display("watchdog expired: %0d pixels queued, %0d awaiting results",
             pixel_queue.size(), escape_queue.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_div.sv
hw/rtl/mbe_datapath.sv
hw/rtl/mbe_ctrl.sv
hw/rtl/mandelbrot_escape_time_pixel.sv
tb/tb_top.sv
